FILE: rtl/core/scs_pkg.sv
// Shared types and constants for the span coverage cell select block.
// Holds the fixed-point layout, the item structs and the status codes.
// Depends on nothing; every other file imports it.
package scs_pkg;

  // Column position layout, unsigned Q(COL_INT_BITS).(FRAC_BITS)
  localparam int unsigned COL_INT_BITS = 16;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned POS_W        = COL_INT_BITS + FRAC_BITS;

  // Field widths of the stream items
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned THR_W    = 9;

  // Coverage arithmetic, in units of one fraction step of a cell
  localparam int unsigned CARRY_W = FRAC_BITS + 2;
  localparam int unsigned SUM_W   = CARRY_W + 1;
  localparam int unsigned CMP_W   = SUM_W + 8;

  localparam logic [CARRY_W-1:0] CARRY_MAX = {CARRY_W{1'b1}};
  localparam logic [THR_W-1:0]   THR_RESET = THR_W'(128);

  // Packed widths on the stream ports
  localparam int unsigned IN_DATA_W  = 2 * ROW_W + 2 * POS_W;
  localparam int unsigned IN_BYTES_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ROW_W + 2 * CELL_W;
  localparam int unsigned OUT_BYTES_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_ROWS  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  // One input span
  typedef struct packed {
    logic [POS_W-1:0] stop_pos;
    logic [POS_W-1:0] start_pos;
    logic [ROW_W-1:0] end_row;
    logic [ROW_W-1:0] span_row;
  } span_t;

  // State carried from one span to the next
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_INT_BITS-1:0] col;
    logic [CARRY_W-1:0]      carry;
  } cov_state_t;

  // Outcome of one span
  typedef struct packed {
    logic              emit;
    status_e           status;
    logic [CELL_W-1:0] hi_cell;
    logic [CELL_W-1:0] lo_cell;
    logic [ROW_W-1:0]  out_row;
  } span_res_t;

  // Coverage test: cov >= threshold, both scaled to a common binary point
  function automatic logic reaches(input logic [SUM_W-1:0] cov,
                                   input logic [THR_W-1:0] thr);
    logic [CMP_W-1:0] lhs;
    logic [CMP_W-1:0] rhs;
    lhs = CMP_W'(cov) << 8;
    rhs = CMP_W'(thr) << FRAC_BITS;
    return lhs >= rhs;
  endfunction

endpackage

FILE: rtl/core/scs_span_eval.sv
// Combinational evaluation of one span against the carried coverage state.
// Produces the result item and the next state; the caller holds both.
// Depends on scs_pkg.
module scs_span_eval
  import scs_pkg::*;
(
  input  span_t            span_i,
  input  cov_state_t       state_i,
  input  logic [THR_W-1:0] thr_i,
  output span_res_t        res_o,
  output cov_state_t       state_o
);

  logic [COL_INT_BITS-1:0] scol;
  logic [COL_INT_BITS-1:0] ecol;
  logic [COL_INT_BITS-1:0] col_gap;
  logic [FRAC_BITS-1:0]    sfrac;
  logic [FRAC_BITS-1:0]    efrac;
  logic                    rows_differ;
  logic                    stop_first;
  logic [CARRY_W-1:0]      cov_base;
  logic [SUM_W-1:0]        same_sum;
  logic [SUM_W-1:0]        start_sum;
  logic                    same_keep;
  logic                    start_keep;
  logic                    stop_keep;
  logic [CARRY_W-1:0]      carry_nx;
  logic                    kept;
  logic [COL_INT_BITS-1:0] first_col;
  logic [COL_INT_BITS-1:0] run_end_col;

  // Split positions into cell and fraction
  assign scol    = span_i.start_pos[POS_W-1:FRAC_BITS];
  assign ecol    = span_i.stop_pos[POS_W-1:FRAC_BITS];
  assign sfrac   = span_i.start_pos[FRAC_BITS-1:0];
  assign efrac   = span_i.stop_pos[FRAC_BITS-1:0];
  assign col_gap = ecol - scol;

  assign rows_differ = span_i.span_row != span_i.end_row;
  assign stop_first  = span_i.stop_pos < span_i.start_pos;

  // Carry only into a span that starts in the last cell of the same row
  assign cov_base = ((span_i.span_row != state_i.row) || (scol != state_i.col)) ?
                    '0 : state_i.carry;

  // Span inside one cell, and the start cell of a wider span
  assign same_sum  = SUM_W'(cov_base) + SUM_W'(efrac - sfrac);
  assign start_sum = SUM_W'(cov_base) + ((SUM_W'(1) << FRAC_BITS) - SUM_W'(sfrac));
  assign same_keep  = reaches(same_sum, thr_i);
  assign start_keep = reaches(start_sum, thr_i);
  assign stop_keep  = reaches(SUM_W'(efrac), thr_i);

  // Select kept run and carried coverage
  always_comb begin
    if (ecol == scol) begin
      kept        = same_keep;
      first_col   = scol;
      run_end_col = scol;
      if (same_keep) begin
        carry_nx = '0;
      end else if (same_sum > SUM_W'(CARRY_MAX)) begin
        carry_nx = CARRY_MAX;
      end else begin
        carry_nx = same_sum[CARRY_W-1:0];
      end
    end else begin
      kept        = start_keep || stop_keep || (col_gap > COL_INT_BITS'(1));
      first_col   = start_keep ? scol : scol + COL_INT_BITS'(1);
      run_end_col = stop_keep ? ecol : ecol - COL_INT_BITS'(1);
      carry_nx    = CARRY_W'(efrac);
    end
  end

  // Result item and next state; errors leave the state alone
  always_comb begin
    res_o.out_row = span_i.span_row;
    res_o.lo_cell = '0;
    res_o.hi_cell = '0;
    state_o       = state_i;
    if (rows_differ) begin
      res_o.emit   = 1'b1;
      res_o.status = ST_ROWS;
    end else if (stop_first) begin
      res_o.emit   = 1'b1;
      res_o.status = ST_ORDER;
    end else begin
      res_o.emit    = kept;
      res_o.status  = ST_OK;
      res_o.lo_cell = CELL_W'(first_col);
      res_o.hi_cell = CELL_W'(run_end_col);
      state_o.row   = span_i.span_row;
      state_o.col   = ecol;
      state_o.carry = carry_nx;
    end
  end

endmodule

FILE: rtl/core/span_coverage_cell_select.sv
// Top level of the span coverage cell select block: stream ports, input and
// result registers, carried coverage state and the threshold register.
// Depends on scs_pkg and scs_span_eval.
//
// Takes one scanline span per cycle while the output is not stalled and
// returns at most one item per span. A span is evaluated against the
// carried coverage in the input register, and its item then waits in the
// result register. The carried state loops through that single evaluation
// stage, so consecutive spans on the same row chain without bubbles. A span
// that keeps no cell produces no item and never occupies the result
// register. Errors (rows differ, stop before start) always produce an item
// with zero cells and leave the carried state untouched. The threshold
// resets to one half; the user must write it through cfg_we_i only while
// no span is in flight, as the block itself does not enforce this.
module span_coverage_cell_select
  import scs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration: coverage_threshold, Q1.8
  input  logic                   cfg_we_i,
  input  logic [THR_W-1:0]       cfg_wdata_i,
  // Spans in; tdata from bit 0: span_row, end_row, start_pos, stop_pos
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
  // Cell runs out; tdata from bit 0: out_row, first kept cell, last kept cell
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_BYTES_W-1:0] m_axis_tdata,
  // tuser: status
  output logic [STATUS_W-1:0]    m_axis_tuser
);

  logic             in_valid_q;
  logic             in_valid_d;
  span_t            in_q;
  logic             out_valid_q;
  logic             out_valid_d;
  span_res_t        out_q;
  cov_state_t       state_q;
  cov_state_t       state_nx;
  logic [THR_W-1:0] thr_q;
  span_res_t        res;
  logic             advance;
  logic             in_take;

  scs_span_eval u_eval (
    .span_i  (in_q),
    .state_i (state_q),
    .thr_i   (thr_q),
    .res_o   (res),
    .state_o (state_nx)
  );

  // Move the held span on when its result has somewhere to go
  assign advance = in_valid_q && (!res.emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  end

  always_comb begin
    if (advance && res.emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      thr_q       <= THR_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_nx;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= s_axis_tdata[IN_DATA_W-1:0];
    end
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_BYTES_W'({out_q.hi_cell, out_q.lo_cell, out_q.out_row});
  assign m_axis_tuser  = out_q.status;

  // An error item carries no cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.status != ST_OK)) |->
      (out_q.lo_cell == '0) && (out_q.hi_cell == '0))
    else $error("error item with non-zero cells");

  // A good run never ends before it starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.status == ST_OK)) |-> (out_q.lo_cell <= out_q.hi_cell))
    else $error("kept run reversed");

  // An erroneous span leaves the carried state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res.status != ST_OK)) |=> $stable(state_q))
    else $error("state changed by erroneous span");

  // An accepted span is held in the input register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted span lost");

endmodule
